FILE: rtl/core/itbc_pkg.sv
package itbc_pkg;

   // command codes on the request side
   localparam logic [1:0] CMD_DATA  = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_CLOSE = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] CSR_END_TIMEOUT     = 2'd0;
   localparam logic [1:0] CSR_PARTIAL_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_MIN_PARTIAL     = 2'd2;
   localparam logic [1:0] CSR_SEND_LEVEL      = 2'd3;

   // result kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_DESC = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_out;
      logic [8:0]  byte_index;
      logic [9:0]  chunk_length;
      logic        new_file;
      logic        end_of_file;
      logic [31:0] stamp;
      logic [31:0] file_number;
      logic [31:0] total_bytes;
      logic        last;
   } rsp_type;

   // results made by one accepted request: count is 0, 1 or 2
   typedef struct packed {
      logic [1:0]          count;
      rsp_type [1:0]       item;
   } push_type;

endpackage

FILE: rtl/core/itbc_rsp_fifo.sv
module itbc_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  itbc_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output itbc_pkg::rsp_type  rsp_item
);
   import itbc_pkg::*;

   localparam int Depth = 4;
   localparam int PW    = $clog2(Depth);
   localparam int CW    = $clog2(Depth + 1);

   rsp_type         entry_ff [Depth];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_item  = entry_ff[rd_ptr_ff];
   // room for a two-result item regardless of the pop
   assign room      = (count_ff <= CW'(Depth - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PW'(push.count);
         rd_ptr_ff <= rd_ptr_ff + PW'(pop);
         count_ff  <= count_ff + CW'(push.count) - CW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.item[0];
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PW'(1)] <= push.item[1];
      end
   end

endmodule

FILE: rtl/core/idle_timeout_byte_chunker.sv
// Byte chunker for a captured parallel-port stream. Each request transfer carries a command in
// req_tuser (data byte, millisecond tick, emergency close) and the byte in req_tdata. A data
// byte echoes one byte result with its chunk position and, when the chunk closes (full, at
// send_level, or aged to partial_timeout with at least min_partial bytes), a descriptor too;
// a tick may close an idle file with an end-of-file descriptor; an emergency close gives a
// zero-length end descriptor. rsp_tlast marks the final result of each request, rsp_tuser is
// the result kind. State updates in the cycle of acceptance, so a request is taken every
// cycle while the four-entry result queue holds at most two results; the response side drains
// one result per cycle while rsp_tready is high; a two-result request takes two transfers.
// The user must write registers through the csr port only while the block is idle (unenforced).
module idle_timeout_byte_chunker #(
   parameter int CHUNK_BYTES = 512
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_in[7:0]
   input  logic [1:0]   req_tuser,   // cmd[1:0]
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // data_out[7:0], byte_index[16:8], chunk_length[26:17], new_file[27],
   // end_of_file[28], stamp[60:29], file_number[92:61], total_bytes[124:93], zero fill
   output logic [127:0] rsp_tdata,
   output logic         rsp_tuser,   // kind[0]
   output logic         rsp_tlast,
   // configuration
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   import itbc_pkg::*;

   localparam int FW = $clog2(CHUNK_BYTES + 1);        // fill count width
   localparam int CW = (FW > 10) ? FW : 10;            // compare width vs 10-bit regs
   localparam logic [FW-1:0] FullCount = FW'(CHUNK_BYTES);
   localparam logic [15:0]   SatCount  = 16'hFFFF;

   // config registers
   logic [15:0] end_timeout_ff;
   logic [15:0] partial_timeout_ff;
   logic [9:0]  min_partial_ff;
   logic [9:0]  send_level_ff;

   // chunker state
   logic          file_open_ff,           file_open_in;
   logic          first_chunk_pending_ff, first_chunk_pending_in;
   logic [FW-1:0] fill_count_ff,          fill_count_in;
   logic [15:0]   chunk_age_ff,           chunk_age_in;
   logic [15:0]   idle_time_ff,           idle_time_in;
   logic [31:0]   now_ms_ff,              now_ms_in;
   logic [31:0]   files_seen_ff,          files_seen_in;
   logic [31:0]   bytes_seen_ff,          bytes_seen_in;

   logic          req_accept;
   logic          opening;
   logic [FW-1:0] base_fill;
   logic [15:0]   base_age;
   logic          base_pending;
   logic [FW-1:0] fill_next;
   logic [CW-1:0] fill_next_wide;
   logic [CW-1:0] base_fill_wide;
   logic [CW-1:0] fill_cur_wide;
   logic          close_chunk;
   logic [31:0]   now_next;
   logic [15:0]   idle_tick;
   logic [15:0]   age_tick;
   rsp_type       res0, res1;
   logic [1:0]    res_count;
   push_type      push;
   logic          room;
   rsp_type       head;

   assign req_tready = room;
   assign req_accept = req_tvalid && room;

   // a data byte into a closed file starts a fresh file and chunk
   assign opening        = !file_open_ff;
   assign base_fill      = opening ? '0 : fill_count_ff;
   assign base_age       = opening ? '0 : chunk_age_ff;
   assign base_pending   = opening ? 1'b1 : first_chunk_pending_ff;
   assign fill_next      = base_fill + FW'(1);
   assign fill_next_wide = CW'(fill_next);
   assign base_fill_wide = CW'(base_fill);
   assign fill_cur_wide  = CW'(fill_count_ff);
   assign close_chunk    = (fill_next >= FullCount)
                        || (fill_next_wide >= CW'(send_level_ff))
                        || ((base_age >= partial_timeout_ff)
                            && (fill_next_wide >= CW'(min_partial_ff)));

   assign now_next  = now_ms_ff + 32'd1;
   assign idle_tick = (idle_time_ff == SatCount) ? idle_time_ff : idle_time_ff + 16'd1;
   assign age_tick  = (chunk_age_ff == SatCount) ? chunk_age_ff : chunk_age_ff + 16'd1;

   always_comb begin
      file_open_in           = file_open_ff;
      first_chunk_pending_in = first_chunk_pending_ff;
      fill_count_in          = fill_count_ff;
      chunk_age_in           = chunk_age_ff;
      idle_time_in           = idle_time_ff;
      now_ms_in              = now_ms_ff;
      files_seen_in          = files_seen_ff;
      bytes_seen_in          = bytes_seen_ff;
      res0      = '0;
      res1      = '0;
      res_count = 2'd0;

      if (req_accept) begin
         unique case (req_tuser)
            CMD_DATA: begin
               idle_time_in           = '0;
               file_open_in           = 1'b1;
               first_chunk_pending_in = base_pending;
               files_seen_in          = files_seen_ff + (opening ? 32'd1 : 32'd0);
               fill_count_in          = base_fill;
               chunk_age_in           = base_age;
               if (base_fill < FullCount) begin
                  bytes_seen_in   = bytes_seen_ff + 32'd1;
                  fill_count_in   = fill_next;
                  res0.kind       = KIND_BYTE;
                  res0.data_out   = req_tdata;
                  res0.byte_index = base_fill_wide[8:0];
                  res0.last       = 1'b1;
                  res_count       = 2'd1;
                  if (close_chunk) begin
                     res0.last              = 1'b0;
                     res1.kind              = KIND_DESC;
                     res1.chunk_length      = fill_next_wide[9:0];
                     res1.new_file          = base_pending;
                     res1.stamp             = now_ms_ff;
                     res1.last              = 1'b1;
                     res_count              = 2'd2;
                     fill_count_in          = '0;
                     first_chunk_pending_in = 1'b0;
                     chunk_age_in           = '0;
                  end
               end
            end
            CMD_TICK: begin
               now_ms_in    = now_next;
               chunk_age_in = age_tick;
               idle_time_in = idle_tick;
               // idle reaching end_timeout closes the file
               if (file_open_ff && (idle_tick >= end_timeout_ff)) begin
                  res0.kind              = KIND_DESC;
                  res0.chunk_length      = fill_cur_wide[9:0];
                  res0.end_of_file       = 1'b1;
                  res0.stamp             = now_next;
                  res0.last              = 1'b1;
                  res_count              = 2'd1;
                  file_open_in           = 1'b0;
                  first_chunk_pending_in = 1'b0;
                  idle_time_in           = '0;
                  fill_count_in          = '0;
                  chunk_age_in           = '0;
               end
            end
            CMD_CLOSE: begin
               // emergency close drops the open chunk
               if (file_open_ff) begin
                  res0.kind              = KIND_DESC;
                  res0.end_of_file       = 1'b1;
                  res0.stamp             = now_ms_ff;
                  res0.last              = 1'b1;
                  res_count              = 2'd1;
                  file_open_in           = 1'b0;
                  first_chunk_pending_in = 1'b0;
                  fill_count_in          = '0;
                  chunk_age_in           = '0;
               end
            end
            default: ;  // unused command, no result
         endcase
      end

      // counters reported after this request's update
      res0.file_number = files_seen_in;
      res0.total_bytes = bytes_seen_in;
      res1.file_number = files_seen_in;
      res1.total_bytes = bytes_seen_in;
   end

   assign push.count   = res_count;
   assign push.item[0] = res0;
   assign push.item[1] = res1;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_open_ff           <= 1'b0;
         first_chunk_pending_ff <= 1'b0;
         fill_count_ff          <= '0;
         chunk_age_ff           <= '0;
         idle_time_ff           <= '0;
         now_ms_ff              <= '0;
         files_seen_ff          <= '0;
         bytes_seen_ff          <= '0;
      end else begin
         file_open_ff           <= file_open_in;
         first_chunk_pending_ff <= first_chunk_pending_in;
         fill_count_ff          <= fill_count_in;
         chunk_age_ff           <= chunk_age_in;
         idle_time_ff           <= idle_time_in;
         now_ms_ff              <= now_ms_in;
         files_seen_ff          <= files_seen_in;
         bytes_seen_ff          <= bytes_seen_in;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         end_timeout_ff     <= 16'd1000;
         partial_timeout_ff <= 16'd100;
         min_partial_ff     <= 10'd64;
         send_level_ff      <= 10'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_END_TIMEOUT:     end_timeout_ff     <= csr_wdata;
            CSR_PARTIAL_TIMEOUT: partial_timeout_ff <= csr_wdata;
            CSR_MIN_PARTIAL:     min_partial_ff     <= csr_wdata[9:0];
            CSR_SEND_LEVEL:      send_level_ff      <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   itbc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (head)
   );

   assign rsp_tdata = {3'b000, head.total_bytes, head.file_number, head.stamp,
                       head.end_of_file, head.new_file, head.chunk_length,
                       head.byte_index, head.data_out};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   // a chunk never stays full: it closes on the byte that fills it
   a_fill_below_full: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff < FullCount)
      else $error("fill count reached chunk size");

   // a closed file holds no bytes and no first-chunk mark
   a_closed_clean: assert property (@(posedge clock) disable iff (reset)
      !file_open_ff |-> (fill_count_ff == '0) && !first_chunk_pending_ff)
      else $error("closed file holds chunk state");

   // a data byte into a closed file opens exactly one new file
   a_file_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == CMD_DATA) && !file_open_ff)
      |=> file_open_ff && (files_seen_ff == $past(files_seen_ff) + 32'd1))
      else $error("file open did not advance file count");

endmodule

FILE: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import itbc_pkg::*;

   localparam int CHUNK_BYTES = 512;
   localparam logic [1:0] CMD_UNUSED = 2'd3;   // not decoded by the block
   localparam int HOLD_CYCLES = 300;           // long receiver hold-off
   localparam int SETTLE_CYCLES = 8;           // quiet cycles after the last result

   // One directed transfer. When typed is set, the expected results are the
   // count entries given here (only zero- or one-result rows are typed);
   // otherwise the predictor supplies them.
   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data;
      logic       typed;
      logic [1:0] count;
      rsp_type    lead;
   } dir_row;

   localparam rsp_type NO_RSP = '0;
   localparam int N_DIR = 22;

   // Directed walk, run with end_timeout 3, partial_timeout 2, min_partial 1,
   // send_level 3 so every close path shows up in a few transfers.
   localparam dir_row DIRECTED [N_DIR] = '{
      '{CMD_UNUSED, 8'hFF, 1'b1, 2'd0, NO_RSP},   // unused command: ignored
      '{CMD_CLOSE,  8'h00, 1'b1, 2'd0, NO_RSP},   // emergency close, no file open
      '{CMD_TICK,   8'h00, 1'b1, 2'd0, NO_RSP},   // tick before any file
      // first byte after reset opens file 1
      '{CMD_DATA,   8'h00, 1'b1, 2'd1,
        '{KIND_BYTE, 8'h00, 9'd0, 10'd0, 1'b0, 1'b0, 32'd0, 32'd1, 32'd1, 1'b1}},
      '{CMD_TICK,   8'h00, 1'b0, 2'd0, NO_RSP},
      '{CMD_TICK,   8'h00, 1'b0, 2'd0, NO_RSP},   // age ripe, but ticks never send
      '{CMD_DATA,   8'hFF, 1'b0, 2'd0, NO_RSP},   // timed partial send, new_file set
      '{CMD_DATA,   8'h5A, 1'b0, 2'd0, NO_RSP},
      '{CMD_DATA,   8'hA5, 1'b0, 2'd0, NO_RSP},
      '{CMD_DATA,   8'h01, 1'b0, 2'd0, NO_RSP},   // send level reached
      '{CMD_TICK,   8'h00, 1'b0, 2'd0, NO_RSP},
      '{CMD_TICK,   8'h00, 1'b0, 2'd0, NO_RSP},
      '{CMD_TICK,   8'h00, 1'b0, 2'd0, NO_RSP},   // end timeout on an empty chunk
      '{CMD_DATA,   8'h80, 1'b0, 2'd0, NO_RSP},   // opens file 2
      '{CMD_TICK,   8'h00, 1'b0, 2'd0, NO_RSP},
      '{CMD_TICK,   8'h00, 1'b0, 2'd0, NO_RSP},
      '{CMD_TICK,   8'h00, 1'b0, 2'd0, NO_RSP},   // end of file before any chunk sent
      '{CMD_DATA,   8'h7F, 1'b0, 2'd0, NO_RSP},   // opens file 3
      '{CMD_CLOSE,  8'h00, 1'b0, 2'd0, NO_RSP},   // emergency close drops the chunk
      '{CMD_UNUSED, 8'h55, 1'b1, 2'd0, NO_RSP},
      '{CMD_CLOSE,  8'h00, 1'b1, 2'd0, NO_RSP},   // no file open again
      '{CMD_TICK,   8'h00, 1'b1, 2'd0, NO_RSP}    // idle, nothing to close
   };

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic [1:0]   req_tuser = CMD_DATA;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = CSR_END_TIMEOUT;
   logic [15:0]  csr_wdata = '0;

   // travels beside the request so the monitor sees the row of each transfer
   logic         row_typed = 1'b0;
   logic [1:0]   row_count = '0;
   rsp_type      row_lead = '0;

   int gap_pct = 0;      // sender idle chance, percent per cycle
   int stall_pct = 0;    // receiver stall chance, percent per cycle
   bit hold_req = 1'b0;  // asks the receiver for one long hold-off
   int bad = 0;

   // chunker predictor: registers and state
   int unsigned end_limit, age_limit, min_fill, level_fill;
   bit          file_live, lead_chunk;
   int unsigned fill, chunk_age, idle_ms;
   logic [31:0] clock_ms, files, bytes_total;
   rsp_type     chunk_q[$];   // results still owed by the block, oldest first

   idle_timeout_byte_chunker #(.CHUNK_BYTES(CHUNK_BYTES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("tb failed");
      $finish;
   end

   // result with the running counters as they stand after this transfer
   function automatic rsp_type chunk_result(logic kind, logic [7:0] d, logic [8:0] idx,
                                            logic [9:0] len, logic nf, logic eof,
                                            logic [31:0] st);
      rsp_type r;
      r = '{kind, d, idx, len, nf, eof, st, files, bytes_total, 1'b0};
      return r;
   endfunction

   // advance the chunker by one accepted transfer and queue what it owes
   task automatic predict_transfer(logic [1:0] cmd, logic [7:0] b, logic typed,
                                   logic [1:0] count, rsp_type lead);
      rsp_type     res [2];
      int          n;
      int unsigned pos;
      n = 0;
      case (cmd)
         CMD_DATA: begin
            idle_ms = 0;
            if (!file_live) begin
               file_live = 1'b1;
               lead_chunk = 1'b1;
               files = files + 1;
               fill = 0;
               chunk_age = 0;
            end
            if (fill < CHUNK_BYTES) begin
               pos = fill;
               fill = fill + 1;
               bytes_total = bytes_total + 1;
               res[n] = chunk_result(KIND_BYTE, b, pos[8:0], '0, 1'b0, 1'b0, '0);
               n = n + 1;
               if (fill >= CHUNK_BYTES || fill >= level_fill ||
                   (chunk_age >= age_limit && fill >= min_fill)) begin
                  res[n] = chunk_result(KIND_DESC, '0, '0, fill[9:0], lead_chunk, 1'b0,
                                        clock_ms);
                  n = n + 1;
                  fill = 0;
                  lead_chunk = 1'b0;
                  chunk_age = 0;
               end
            end
         end
         CMD_TICK: begin
            clock_ms = clock_ms + 1;
            if (chunk_age < 16'hFFFF) chunk_age = chunk_age + 1;
            if (idle_ms < 16'hFFFF) idle_ms = idle_ms + 1;
            if (file_live && idle_ms >= end_limit) begin
               res[n] = chunk_result(KIND_DESC, '0, '0, fill[9:0], 1'b0, 1'b1, clock_ms);
               n = n + 1;
               file_live = 1'b0;
               lead_chunk = 1'b0;
               idle_ms = 0;
               fill = 0;
               chunk_age = 0;
            end
         end
         CMD_CLOSE: begin
            if (file_live) begin
               res[n] = chunk_result(KIND_DESC, '0, '0, '0, 1'b0, 1'b1, clock_ms);
               n = n + 1;
               file_live = 1'b0;
               lead_chunk = 1'b0;
               fill = 0;
               chunk_age = 0;
            end
         end
         default: ;
      endcase
      if (n > 0) res[n - 1].last = 1'b1;
      if (typed) begin
         if (count != 0) chunk_q.push_back(lead);
      end else begin
         for (int i = 0; i < n; i++) chunk_q.push_back(res[i]);
      end
   endtask

   function automatic bit same_result(rsp_type a, rsp_type b);
      return a.kind === b.kind && a.data_out === b.data_out &&
             a.byte_index === b.byte_index && a.chunk_length === b.chunk_length &&
             a.new_file === b.new_file && a.end_of_file === b.end_of_file &&
             a.stamp === b.stamp && a.file_number === b.file_number &&
             a.total_bytes === b.total_bytes && a.last === b.last;
   endfunction

   // Monitor: register writes, request transfers and result transfers, all
   // sampled at the rising edge. Prediction runs before the check so a
   // same-cycle bypass inside the block would still line up.
   always @(posedge clock) begin : monitor
      rsp_type got, wanted;
      if (reset) begin
         end_limit = 1000;
         age_limit = 100;
         min_fill = 64;
         level_fill = 256;
         file_live = 1'b0;
         lead_chunk = 1'b0;
         fill = 0;
         chunk_age = 0;
         idle_ms = 0;
         clock_ms = '0;
         files = '0;
         bytes_total = '0;
         chunk_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_END_TIMEOUT:     end_limit = csr_wdata;
               CSR_PARTIAL_TIMEOUT: age_limit = csr_wdata;
               CSR_MIN_PARTIAL:     min_fill = csr_wdata[9:0];
               CSR_SEND_LEVEL:      level_fill = csr_wdata[9:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_transfer(req_tuser, req_tdata, row_typed, row_count, row_lead);
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[7:0], rsp_tdata[16:8], rsp_tdata[26:17],
                    rsp_tdata[27], rsp_tdata[28], rsp_tdata[60:29], rsp_tdata[92:61],
                    rsp_tdata[124:93], rsp_tlast};
            if (chunk_q.size() == 0) begin
               bad++;
               if (bad <= 10) $display("%0t: result with nothing owed: %p", $time, got);
            end else begin
               wanted = chunk_q.pop_front();
               if (!same_result(wanted, got)) begin
                  bad++;
                  if (bad <= 10)
                     $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                              $time, wanted, got);
               end
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // one request transfer; returns right after the accepting edge
   task automatic push_request(logic [1:0] cmd, logic [7:0] b, logic typed = 1'b0,
                               logic [1:0] count = '0, rsp_type lead = '0);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= b;
      row_typed <= typed;
      row_count <= count;
      row_lead <= lead;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // all four registers, one per cycle; upper bits of the 10-bit ones are junk
   task automatic write_regs(logic [15:0] end_ms, logic [15:0] age_ms,
                             logic [9:0] min_bytes, logic [9:0] level_bytes);
      csr_we <= 1'b1;
      csr_index <= CSR_END_TIMEOUT;
      csr_wdata <= end_ms;
      @(posedge clock);
      csr_index <= CSR_PARTIAL_TIMEOUT;
      csr_wdata <= age_ms;
      @(posedge clock);
      csr_index <= CSR_MIN_PARTIAL;
      csr_wdata <= {6'($urandom), min_bytes};
      @(posedge clock);
      csr_index <= CSR_SEND_LEVEL;
      csr_wdata <= {6'($urandom), level_bytes};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // stop offering, wait for every owed result, then let the block go quiet.
   // It first lets the monitor queue the last transfer's results.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (chunk_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random traffic; the weights are percent, the rest is the unused command
   task automatic run_traffic(int items, int data_pct, int tick_pct, int close_pct);
      int          roll;
      logic [1:0]  cmd;
      for (int i = 0; i < items; i++) begin
         roll = $urandom_range(99);
         if (roll < data_pct) cmd = CMD_DATA;
         else if (roll < data_pct + tick_pct) cmd = CMD_TICK;
         else if (roll < data_pct + tick_pct + close_pct) cmd = CMD_CLOSE;
         else cmd = CMD_UNUSED;
         push_request(cmd, 8'($urandom));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed walk, no idling
      write_regs(16'd3, 16'd2, 10'd1, 10'd3);
      foreach (DIRECTED[i])
         push_request(DIRECTED[i].cmd, DIRECTED[i].data, DIRECTED[i].typed,
                      DIRECTED[i].count, DIRECTED[i].lead);
      drain_results();

      // short timeouts and small levels: frequent closes of every kind
      write_regs(16'($urandom_range(12, 2)), 16'($urandom_range(8, 1)),
                 10'($urandom_range(6, 1)), 10'($urandom_range(24, 3)));
      run_traffic(25, 60, 30, 5);
      drain_results();

      // all registers zero: each byte closes its chunk, each tick its file
      gap_pct = 61;
      write_regs(16'd0, 16'd0, 10'd0, 10'd0);
      run_traffic(20, 60, 25, 10);
      drain_results();

      // top values, levels above the chunk size: only a full chunk closes.
      // Chunk starts empty here, so 512 bytes fill it exactly once.
      // Starts with a long receiver hold-off while the sender keeps pushing.
      gap_pct = 0;
      stall_pct = 0;
      write_regs(16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF);
      hold_req = 1'b1;
      run_traffic(128, 100, 0, 0);
      gap_pct = 61;
      run_traffic(128, 100, 0, 0);
      gap_pct = 0;
      stall_pct = 61;
      run_traffic(128, 100, 0, 0);
      gap_pct = 36;
      stall_pct = 36;
      run_traffic(128, 100, 0, 0);
      drain_results();

      // mixed settings, both sides idling
      write_regs(16'($urandom_range(8, 0)), 16'($urandom_range(6, 0)),
                 10'($urandom_range(10, 0)), 10'($urandom_range(1023, 0)));
      run_traffic(25, 55, 35, 5);
      drain_results();

      if (bad == 0 && chunk_q.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/itbc_pkg.sv
rtl/core/itbc_rsp_fifo.sv
rtl/core/idle_timeout_byte_chunker.sv
tb/tb.sv
